/* rtl/bresenham_line_pixel_generator_unit_assert.svh */
// Assertion macros used by the line generator back end.
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_UNIT_ASSERT_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLPG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BLPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/blpg_pkg.sv */
// Shared constants and types of the line pixel generator.
package blpg_pkg;

	localparam int ADDR_BITS   = 26;
	localparam int COLOR_BITS  = 24;
	localparam int RW_BITS     = 13;
	localparam int RW3_BITS    = RW_BITS + 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic [RW_BITS-1:0]  RW_RESET  = 13'd640;
	localparam logic [RW3_BITS-1:0] RW3_RESET = 15'd1920;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* rtl/blpg_cmd_if.sv */
// Command channel: one word starts a line or steps the running one.
interface blpg_cmd_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic                  op;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;
	logic [7:0]            color_red;
	logic [7:0]            color_green;
	logic [7:0]            color_blue;

	modport source (
		output valid, op, start_x, start_y, end_x, end_y,
		       color_red, color_green, color_blue,
		input  ready
	);

	modport sink (
		input  valid, op, start_x, start_y, end_x, end_y,
		       color_red, color_green, color_blue,
		output ready
	);
endinterface

/* rtl/blpg_pix_if.sv */
// Pixel channel: one word per command, carrying the generated pixel, or none for an idle step.
interface blpg_pix_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic                  pixel_valid;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [25:0]           pixel_address;
	logic [7:0]            pixel_red;
	logic [7:0]            pixel_green;
	logic [7:0]            pixel_blue;
	logic                  last_pixel;

	modport source (
		output valid, pixel_valid, pixel_x, pixel_y, pixel_address,
		       pixel_red, pixel_green, pixel_blue, last_pixel,
		input  ready
	);

	modport sink (
		input  valid, pixel_valid, pixel_x, pixel_y, pixel_address,
		       pixel_red, pixel_green, pixel_blue, last_pixel,
		output ready
	);
endinterface

/* rtl/blpg_queue.sv */
// Small first-in first-out queue between the front and back ends.
module blpg_queue #(
	parameter int W = 113
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [W-1:0]          push_data,
	input  logic                  pop,
	output logic [W-1:0]          pop_data,
	output blpg_pkg::q_status_t   status
);
	import blpg_pkg::*;

	logic [W-1:0]         entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	assign pop_data     = entry_q[rd_ptr_q];
	assign status.full  = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
endmodule

/* rtl/blpg_front.sv */
// Front end: takes command words and works out the line set-up for starts.
module blpg_front #(
	parameter int  COORD_BITS = 12,
	localparam int EW         = 7 * COORD_BITS + 29
) (
	blpg_cmd_if.sink             cmd,
	input  blpg_pkg::q_status_t  q_status,
	output logic                 push,
	output logic [EW-1:0]        push_data
);
	import blpg_pkg::*;

	localparam int ET = COORD_BITS + 2;

	typedef struct packed {
		logic                  op;
		logic [COORD_BITS-1:0] sx;
		logic [COORD_BITS-1:0] sy;
		logic [COORD_BITS-1:0] ex;
		logic [COORD_BITS-1:0] ey;
		logic [COORD_BITS-1:0] dx;
		logic [COORD_BITS-1:0] dy;
		logic                  negx;
		logic                  negy;
		logic signed [ET-1:0]  err;
		logic [COLOR_BITS-1:0] color;
	} entry_t;

	entry_t ent;
	logic   x_up;
	logic   y_up;

	always_comb begin
		x_up      = cmd.start_x < cmd.end_x;
		y_up      = cmd.start_y < cmd.end_y;
		ent.op    = cmd.op;
		ent.sx    = cmd.start_x;
		ent.sy    = cmd.start_y;
		ent.ex    = cmd.end_x;
		ent.ey    = cmd.end_y;
		ent.dx    = x_up ? (cmd.end_x - cmd.start_x) : (cmd.start_x - cmd.end_x);
		ent.dy    = y_up ? (cmd.end_y - cmd.start_y) : (cmd.start_y - cmd.end_y);
		ent.negx  = !x_up;
		ent.negy  = !y_up;
		// The error term starts at half the major delta, negative unless dx exceeds dy.
		if (ent.dx > ent.dy)
			ent.err = signed'({2'b00, ent.dx >> 1});
		else
			ent.err = -signed'({2'b00, ent.dy >> 1});
		ent.color = {cmd.color_red, cmd.color_green, cmd.color_blue};
	end

	assign cmd.ready = !q_status.full;
	assign push      = cmd.valid && !q_status.full;
	assign push_data = ent;
endmodule

/* rtl/blpg_back.sv */
// Back end: runs the line stepper and computes the framebuffer byte offset.
`include "bresenham_line_pixel_generator_unit_assert.svh"

module blpg_back #(
	parameter int  COORD_BITS = 12,
	localparam int EW         = 7 * COORD_BITS + 29
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [EW-1:0]                 q_data,
	input  blpg_pkg::q_status_t           q_status,
	output logic                          pop,
	input  logic [blpg_pkg::RW3_BITS-1:0] rw3,
	blpg_pix_if.source                    pix
);
	import blpg_pkg::*;

	localparam int ET       = COORD_BITS + 2;
	localparam int SUM_BITS = COORD_BITS + RW3_BITS + 1;
	localparam int AW       = (SUM_BITS > ADDR_BITS) ? SUM_BITS : ADDR_BITS;

	typedef struct packed {
		logic                  op;
		logic [COORD_BITS-1:0] sx;
		logic [COORD_BITS-1:0] sy;
		logic [COORD_BITS-1:0] ex;
		logic [COORD_BITS-1:0] ey;
		logic [COORD_BITS-1:0] dx;
		logic [COORD_BITS-1:0] dy;
		logic                  negx;
		logic                  negy;
		logic signed [ET-1:0]  err;
		logic [COLOR_BITS-1:0] color;
	} entry_t;

	entry_t ent;

	// Line state
	logic                  active_q;
	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q, dx_q, dy_q;
	logic                  negx_q, negy_q;
	logic signed [ET-1:0]  err_q;
	logic [COLOR_BITS-1:0] color_q;

	// Step computation
	logic signed [ET-1:0]  sdx, sdy, err_nxt;
	logic                  go_x, go_y;
	logic [COORD_BITS-1:0] x_nxt, y_nxt;
	logic                  is_start, start_last, step_last;

	// Result of the word being popped
	logic                  res_pv, res_last;
	logic [COORD_BITS-1:0] res_x, res_y;
	logic [COLOR_BITS-1:0] res_color;

	// Pipeline
	logic                  v_s1, pv_s1, last_s1;
	logic [COORD_BITS-1:0] x_s1, y_s1;
	logic [COLOR_BITS-1:0] color_s1;
	logic                  v_s2, pv_s2, last_s2;
	logic [COORD_BITS-1:0] x_s2, y_s2;
	logic [ADDR_BITS-1:0]  addr_s2;
	logic [COLOR_BITS-1:0] color_s2;
	logic                  adv1, adv2;
	logic [AW-1:0]         addr_full;

	assign ent  = entry_t'(q_data);
	assign adv2 = !v_s2 || pix.ready;
	assign adv1 = !v_s1 || adv2;
	assign pop  = !q_status.empty && adv1;

	always_comb begin
		sdx     = signed'({2'b00, dx_q});
		sdy     = signed'({2'b00, dy_q});
		go_x    = err_q > -sdx;
		go_y    = err_q < sdy;
		err_nxt = err_q - (go_x ? sdy : '0) + (go_y ? sdx : '0);
		x_nxt   = cur_x_q;
		y_nxt   = cur_y_q;
		if (go_x)
			x_nxt = negx_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
		if (go_y)
			y_nxt = negy_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
		step_last  = (x_nxt == tgt_x_q) && (y_nxt == tgt_y_q);
		is_start   = (ent.op == OP_START);
		start_last = (ent.sx == ent.ex) && (ent.sy == ent.ey);
	end

	always_comb begin
		res_pv    = 1'b0;
		res_last  = 1'b0;
		res_x     = '0;
		res_y     = '0;
		res_color = '0;
		priority if (is_start) begin
			res_pv    = 1'b1;
			res_last  = start_last;
			res_x     = ent.sx;
			res_y     = ent.sy;
			res_color = ent.color;
		end else if (active_q) begin
			res_pv    = 1'b1;
			res_last  = step_last;
			res_x     = x_nxt;
			res_y     = y_nxt;
			res_color = color_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (pop) begin
				if (is_start)
					active_q <= !start_last;
				else if (active_q && step_last)
					active_q <= 1'b0;
			end
			if (adv1)
				v_s1 <= pop;
			if (adv2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (is_start) begin
				cur_x_q <= ent.sx;
				cur_y_q <= ent.sy;
				tgt_x_q <= ent.ex;
				tgt_y_q <= ent.ey;
				dx_q    <= ent.dx;
				dy_q    <= ent.dy;
				negx_q  <= ent.negx;
				negy_q  <= ent.negy;
				err_q   <= ent.err;
				color_q <= ent.color;
			end else if (active_q) begin
				cur_x_q <= x_nxt;
				cur_y_q <= y_nxt;
				err_q   <= err_nxt;
			end
		end
		if (adv1) begin
			pv_s1    <= res_pv;
			last_s1  <= res_last;
			x_s1     <= res_x;
			y_s1     <= res_y;
			color_s1 <= res_color;
		end
		if (adv2) begin
			pv_s2    <= pv_s1;
			last_s2  <= last_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			color_s2 <= color_s1;
			addr_s2  <= addr_full[ADDR_BITS-1:0];
		end
	end

	// Byte offset: x*3 + y*(row_width*3), wrapped to the address width.
	assign addr_full = AW'(y_s1) * AW'(rw3) + AW'(x_s1) + (AW'(x_s1) << 1);

	assign pix.valid         = v_s2;
	assign pix.pixel_valid   = pv_s2;
	assign pix.pixel_x       = x_s2;
	assign pix.pixel_y       = y_s2;
	assign pix.pixel_address = addr_s2;
	assign pix.pixel_red     = color_s2[23:16];
	assign pix.pixel_green   = color_s2[15:8];
	assign pix.pixel_blue    = color_s2[7:0];
	assign pix.last_pixel    = last_s2;

	`BLPG_ASSERT_NOW(a_active_not_at_end, clk, arst_n, active_q,
		!((cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q)), "active line sits on its endpoint")
	`BLPG_ASSERT_NEXT(a_last_ends_line, clk, arst_n, pop && res_last, !active_q,
		"line still active after its last pixel")
	`BLPG_ASSERT_NOW(a_idle_word_zero, clk, arst_n, v_s1 && !pv_s1,
		(x_s1 == '0) && (y_s1 == '0) && !last_s1 && (color_s1 == '0),
		"idle step word carries non-zero fields")
endmodule

/* rtl/bresenham_line_pixel_generator_unit.sv */
// Latency: an accepted command word passes through the queue and the registered stages s1 and s2.
// Throughput: one command word per clock while the output is not stalled; a four-entry queue
// lets the front keep accepting while the output is stalled, until the queue is full.
// Reset clears the queue, the pipeline valid flags and the line-active flag, and sets the
// row width to 640 pixels.
// Top level of the line pixel generator.
module bresenham_line_pixel_generator_unit #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [blpg_pkg::RW_BITS-1:0] cfg_wr_data,
	blpg_cmd_if.sink                     cmd,
	blpg_pix_if.source                   pix
);
	import blpg_pkg::*;

	localparam int EW = 7 * COORD_BITS + 29;

	// The row width is kept premultiplied by three bytes per pixel, so that the address stage needs
	// only one multiplier. The user must write it while the block idles; the block does not check this.
	logic [RW3_BITS-1:0] rw3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rw3_q <= RW3_RESET;
		end else if (cfg_wr_en) begin
			rw3_q <= {2'b00, cfg_wr_data} + {1'b0, cfg_wr_data, 1'b0};
		end
	end

	// The front works out deltas, step directions and the initial error term
	// of a start word and pushes every command word into the queue.
	logic          push;
	logic [EW-1:0] push_data;
	logic          pop;
	logic [EW-1:0] pop_data;
	q_status_t     q_status;

	blpg_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.cmd       (cmd),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	blpg_queue #(
		.W (EW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	// The back holds the line state, steps it once per popped word and
	// registers the pixel, then forms the byte offset in the output stage.
	blpg_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_data   (pop_data),
		.q_status (q_status),
		.pop      (pop),
		.rw3      (rw3_q),
		.pix      (pix)
	);
endmodule

/* tb/sv/bresenham_line_pixel_generator_unit_tb.sv */
// Self-checking testbench of the line pixel generator: random and directed lines, scoreboarded.
`timescale 1ns / 100ps

module bresenham_line_pixel_generator_unit_tb;

	import blpg_pkg::*;

	localparam int CB = 12;
	// Cycles without any handshake before the run is declared hung.
	localparam int QUIET_LIMIT = 5000;
	// Latency of the block plus a little margin, used once at the very end.
	localparam int TAIL_CYCLES = 4;
	// Each side holds off in about this many cycles of a hundred.
	localparam int IDLE_PCT = 28;

	// One command word as the sender presents it.
	typedef struct packed {
		logic          op;
		logic [CB-1:0] sx;
		logic [CB-1:0] sy;
		logic [CB-1:0] ex;
		logic [CB-1:0] ey;
		logic [7:0]    red;
		logic [7:0]    green;
		logic [7:0]    blue;
	} cmd_word_t;

	// One pixel word as the block should return it.
	typedef struct packed {
		logic               pvalid;
		logic [CB-1:0]      x;
		logic [CB-1:0]      y;
		logic [ADDR_BITS-1:0] addr;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic               at_end;
	} pixel_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic               cfg_wr_en = 1'b0;
	logic [RW_BITS-1:0] cfg_wr_data = '0;

	blpg_cmd_if #(.COORD_BITS(CB)) cmd ();
	blpg_pix_if #(.COORD_BITS(CB)) pix ();

	bresenham_line_pixel_generator_unit #(
		.COORD_BITS(CB)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd        (cmd.sink),
		.pix        (pix.source)
	);

	always #1 clk = ~clk;

	// Words waiting to be sent, and pixels the block still owes us.
	cmd_word_t   cmd_backlog[$];
	pixel_word_t expected_pixels[$];

	int mismatch_count = 0;
	int quiet_cycles = 0;
	// While set, neither side holds off: a long stretch at full rate.
	bit calm = 1'b0;

	// Our own copy of the line walker. The row width only changes while idle,
	// so it can be updated at the moment the write is issued.
	logic               line_active = 1'b0;
	logic [CB-1:0]      cur_x = '0;
	logic [CB-1:0]      cur_y = '0;
	logic [CB-1:0]      tgt_x = '0;
	logic [CB-1:0]      tgt_y = '0;
	logic [CB-1:0]      span_x = '0;
	logic [CB-1:0]      span_y = '0;
	logic               dir_x_neg = 1'b0;
	logic               dir_y_neg = 1'b0;
	int                 err_acc = 0;
	logic [23:0]        line_rgb = '0;
	logic [RW_BITS-1:0] row_width_now = RW_RESET;

	// Build the pixel word for the current position of the walker.
	function automatic pixel_word_t current_pixel(logic at_end);
		pixel_word_t p;
		int unsigned offset;
		offset = 32'(cur_x) * 3 + 32'(cur_y) * (32'(row_width_now) * 3);
		p.pvalid = 1'b1;
		p.x      = cur_x;
		p.y      = cur_y;
		p.addr   = offset[ADDR_BITS-1:0];
		p.red    = line_rgb[23:16];
		p.green  = line_rgb[15:8];
		p.blue   = line_rgb[7:0];
		p.at_end = at_end;
		return p;
	endfunction

	// Apply one accepted command to the walker and return the pixel it yields.
	function automatic pixel_word_t walk_line(cmd_word_t c);
		int          e2;
		logic        at_end;
		pixel_word_t p;
		if (c.op == OP_START) begin
			// A start always wins, even if a line is still being drawn.
			cur_x     = c.sx;
			cur_y     = c.sy;
			tgt_x     = c.ex;
			tgt_y     = c.ey;
			span_x    = (c.sx < c.ex) ? c.ex - c.sx : c.sx - c.ex;
			span_y    = (c.sy < c.ey) ? c.ey - c.sy : c.sy - c.ey;
			dir_x_neg = !(c.sx < c.ex);
			dir_y_neg = !(c.sy < c.ey);
			err_acc   = (span_x > span_y) ? int'(span_x >> 1) : -int'(span_y >> 1);
			line_rgb  = {c.red, c.green, c.blue};
			at_end    = (cur_x == tgt_x) && (cur_y == tgt_y);
			line_active = !at_end;
			return current_pixel(at_end);
		end
		if (!line_active) begin
			// Stepping with no line running gives an all-zero word.
			p = '0;
			return p;
		end
		e2 = err_acc;
		if (e2 > -int'(span_x)) begin
			err_acc -= int'(span_y);
			cur_x = dir_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
		end
		if (e2 < int'(span_y)) begin
			err_acc += int'(span_x);
			cur_y = dir_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
		end
		at_end = (cur_x == tgt_x) && (cur_y == tgt_y);
		if (at_end) begin
			line_active = 1'b0;
		end
		return current_pixel(at_end);
	endfunction

	// Driver: a word that is up stays up until it is taken; a new word is
	// offered, or withheld at random, only once the previous one has gone.
	always @(posedge clk or negedge arst_n) begin
		cmd_word_t w;
		if (!arst_n) begin
			cmd.valid       <= 1'b0;
			cmd.op          <= OP_START;
			cmd.start_x     <= '0;
			cmd.start_y     <= '0;
			cmd.end_x       <= '0;
			cmd.end_y       <= '0;
			cmd.color_red   <= '0;
			cmd.color_green <= '0;
			cmd.color_blue  <= '0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				w = {cmd.op, cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y,
				     cmd.color_red, cmd.color_green, cmd.color_blue};
				expected_pixels.push_back(walk_line(w));
			end
			if (!cmd.valid || cmd.ready) begin
				if (cmd_backlog.size() != 0 &&
				    (calm || $urandom_range(99) >= IDLE_PCT)) begin
					w = cmd_backlog.pop_front();
					cmd.valid       <= 1'b1;
					cmd.op          <= w.op;
					cmd.start_x     <= w.sx;
					cmd.start_y     <= w.sy;
					cmd.end_x       <= w.ex;
					cmd.end_y       <= w.ey;
					cmd.color_red   <= w.red;
					cmd.color_green <= w.green;
					cmd.color_blue  <= w.blue;
				end else begin
					cmd.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [ADDR_BITS-1:0] want,
	                           logic [ADDR_BITS-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Monitor: every pixel word taken is compared with the oldest one owed.
	always @(posedge clk or negedge arst_n) begin
		pixel_word_t want;
		if (!arst_n) begin
			pix.ready <= 1'b0;
		end else begin
			if (pix.valid && pix.ready) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected pixel word, expected none actual x=%h y=%h",
					         $time, pix.pixel_x, pix.pixel_y);
					mismatch_count++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("pixel_valid", 26'(want.pvalid), 26'(pix.pixel_valid));
					check_field("pixel_x", 26'(want.x), 26'(pix.pixel_x));
					check_field("pixel_y", 26'(want.y), 26'(pix.pixel_y));
					check_field("pixel_address", want.addr, pix.pixel_address);
					check_field("pixel_red", 26'(want.red), 26'(pix.pixel_red));
					check_field("pixel_green", 26'(want.green), 26'(pix.pixel_green));
					check_field("pixel_blue", 26'(want.blue), 26'(pix.pixel_blue));
					check_field("last_pixel", 26'(want.at_end), 26'(pix.last_pixel));
				end
			end
			pix.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: a run that moves no word for too long is hung.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((cmd.valid && cmd.ready) || (pix.valid && pix.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
				$display("bresenham_line_pixel_generator_unit_tb: FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic queue_start(int sx, int sy, int ex, int ey, int r, int g, int b);
		cmd_word_t w;
		w.op    = OP_START;
		w.sx    = CB'(sx);
		w.sy    = CB'(sy);
		w.ex    = CB'(ex);
		w.ey    = CB'(ey);
		w.red   = 8'(r);
		w.green = 8'(g);
		w.blue  = 8'(b);
		cmd_backlog.push_back(w);
	endtask

	// Steps carry random junk in the fields that a step ignores.
	task automatic queue_steps(int n);
		cmd_word_t w;
		for (int i = 0; i < n; i++) begin
			w.op    = OP_STEP;
			w.sx    = CB'($urandom);
			w.sy    = CB'($urandom);
			w.ex    = CB'($urandom);
			w.ey    = CB'($urandom);
			w.red   = 8'($urandom);
			w.green = 8'($urandom);
			w.blue  = 8'($urandom);
			cmd_backlog.push_back(w);
		end
	endtask

	// Coordinates lean towards the borders now and then.
	function automatic int pick_coord();
		if ($urandom_range(7) == 0) begin
			return $urandom_range(1) ? 4095 : 0;
		end
		return $urandom_range(4095);
	endfunction

	// A coordinate close to v, clamped to the frame.
	function automatic int near(int v);
		int t;
		t = v + int'($urandom_range(24)) - 12;
		if (t < 0) begin
			t = 0;
		end else if (t > 4095) begin
			t = 4095;
		end
		return t;
	endfunction

	// Mostly complete lines with random content; some are cut short by the
	// next start, some overrun into idle steps, and a few words are noise.
	task automatic queue_random_traffic(int n);
		int made;
		int sx, sy, ex, ey, len;
		cmd_word_t w;
		logic [95:0] noise;
		made = 0;
		while (made < n) begin
			if ($urandom_range(99) < 10) begin
				noise = {$urandom, $urandom, $urandom};
				w = noise[$bits(cmd_word_t)-1:0];
				cmd_backlog.push_back(w);
				made++;
			end else begin
				sx = pick_coord();
				sy = pick_coord();
				if ($urandom_range(4) == 0) begin
					// Long line across the frame: it is nearly always dropped early.
					ex  = pick_coord();
					ey  = pick_coord();
					len = $urandom_range(30);
				end else begin
					ex  = near(sx);
					ey  = near(sy);
					len = (ex > sx ? ex - sx : sx - ex);
					if ((ey > sy ? ey - sy : sy - ey) > len) begin
						len = (ey > sy ? ey - sy : sy - ey);
					end
					len += $urandom_range(2);
					if ($urandom_range(9) == 0) begin
						len = $urandom_range(len);
					end
				end
				queue_start(sx, sy, ex, ey, $urandom_range(255), $urandom_range(255),
				            $urandom_range(255));
				queue_steps(len);
				made += 1 + len;
			end
		end
	endtask

	// Hold the sender until everything sent has come back.
	task automatic drain();
		do @(negedge clk);
		while (cmd_backlog.size() != 0 || cmd.valid || expected_pixels.size() != 0);
	endtask

	task automatic set_row_width(logic [RW_BITS-1:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		row_width_now = v;
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, at the reset row width. A step straight after reset
		// finds no line running.
		queue_steps(1);
		// A single-point line ends at once; the step after it is idle.
		queue_start(0, 0, 0, 0, 'h00, 'h00, 'h00);
		queue_steps(1);
		queue_start(4095, 4095, 4095, 4095, 'hff, 'hff, 'hff);
		// A shallow line run to its end and one step beyond.
		queue_start(0, 0, 3, 1, 'ha5, 'h5a, 'h3c);
		queue_steps(4);
		// A diagonal line dropped by a new start going left and down.
		queue_start(10, 10, 20, 20, 'h12, 'h34, 'h56);
		queue_steps(1);
		queue_start(4095, 0, 4092, 3, 'h80, 'h01, 'hfe);
		queue_steps(3);
		// Both directions negative, and then a steep line.
		queue_start(5, 4095, 0, 4093, 'h01, 'h80, 'h7f);
		queue_steps(5);
		queue_start(2000, 100, 2001, 104, 'hc3, 'h3c, 'h99);
		queue_steps(4);
		drain();

		// Narrowest row, at full rate on both sides.
		set_row_width(13'd1);
		calm = 1'b1;
		queue_random_traffic(200);
		drain();
		calm = 1'b0;

		// Widest row used here: the largest offsets still fit in the address range.
		set_row_width(13'd4096);
		queue_random_traffic(200);
		drain();

		repeat (2) begin
			set_row_width(RW_BITS'($urandom_range(4096, 1)));
			queue_random_traffic(200);
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("bresenham_line_pixel_generator_unit_tb: PASS");
		end else begin
			$display("bresenham_line_pixel_generator_unit_tb: FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/blpg_pkg.sv
rtl/blpg_cmd_if.sv
rtl/blpg_pix_if.sv
rtl/blpg_queue.sv
rtl/blpg_front.sv
rtl/blpg_back.sv
rtl/bresenham_line_pixel_generator_unit.sv
tb/sv/bresenham_line_pixel_generator_unit_tb.sv
